@@ hw/rtl/rmsi_pkg.sv @@
// shared types and constants for the running median block
// used by rmsi_cell and running_median_sorted_insert, no dependencies
`default_nettype none

package rmsi_pkg;

  localparam int DEPTH    = 1024;
  localparam int WORD_W   = 32;
  localparam int LO_CELLS = DEPTH / 2;
  localparam int HI_CELLS = DEPTH - LO_CELLS;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POPINS,
    OP_PUSH
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    word_t    value;
  } cell_cmd_t;

  typedef struct packed {
    word_t val;
    logic  keep;
    logic  pre;
  } cell_nb_t;

  localparam cell_nb_t NB_HEAD = '{val: '0, keep: 1'b1, pre: 1'b0};
  localparam cell_nb_t NB_TAIL = '{val: '0, keep: 1'b0, pre: 1'b0};

endpackage

`default_nettype wire

@@ hw/rtl/running_median_sorted_insert.sv @@
// running median top level: two sorted cell chains around the median
// depends on rmsi_pkg and rmsi_cell
//
//   channel  dir  tdata         tuser
//   s_       in   value[31:0]   first
//   m_       out  median[31:0]  dropped
//
// one item per cycle unless stalled; items go in when taken, or drop if full
// the lower chain holds the lower half largest first, the upper chain the rest
// smallest first, so at an odd count the median is the upper chain's head
// a result shows in the cycle after its item and holds the chains until taken
// reset clears the entry count and the result flag, no clearing pass
`default_nettype none

module running_median_sorted_insert (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // value
  input  logic                  s_tuser,   // first
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // median
  output logic                  m_tuser    // dropped
);
  import rmsi_pkg::*;

  count_t    cnt;
  count_t    cnt_eff;
  count_t    n_lo;
  logic      out_valid;
  logic      out_drop;
  logic      accept;
  logic      full;
  word_t     v;
  word_t     lo_head;
  word_t     hi_head;
  cell_cmd_t lo_cmd;
  cell_cmd_t hi_cmd;
  cell_nb_t  lo_nb [LO_CELLS];
  cell_nb_t  hi_nb [HI_CELLS];

  assign v        = word_t'(s_tdata);
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign cnt_eff  = s_tuser ? '0 : cnt;
  assign n_lo     = cnt_eff >> 1;
  assign full     = (cnt_eff == count_t'(DEPTH));
  assign lo_head  = lo_nb[0].val;
  assign hi_head  = hi_nb[0].val;

  always_comb begin
    lo_cmd = '{op: OP_HOLD, value: v};
    hi_cmd = '{op: OP_HOLD, value: v};
    if (accept && !full) begin
      if (!cnt_eff[0]) begin
        if (cnt_eff == '0 || v >= lo_head) begin
          hi_cmd.op = OP_INSERT;
        end else begin
          lo_cmd.op = OP_POPINS;
          hi_cmd.op = OP_PUSH;
        end
      end else begin
        if (v < hi_head) begin
          lo_cmd.op = OP_INSERT;
        end else begin
          hi_cmd.op = OP_POPINS;
          lo_cmd.op = OP_PUSH;
        end
      end
    end
  end

  for (genvar i = 0; i < LO_CELLS; i++) begin : g_lo
    cell_nb_t left_nb;
    cell_nb_t right_nb;
    word_t    front_v;
    logic     vld;
    assign vld = (count_t'(i) < n_lo);
    if (i == 0) begin : g_head
      assign left_nb = NB_HEAD;
      assign front_v = hi_head;
    end else begin : g_body
      assign left_nb = lo_nb[i-1];
      assign front_v = lo_nb[i-1].val;
    end
    if (i == LO_CELLS - 1) begin : g_tail
      assign right_nb = NB_TAIL;
    end else begin : g_mid
      assign right_nb = lo_nb[i+1];
    end
    rmsi_cell u_cell (
      .clk        (clk),
      .cmd        (lo_cmd),
      .descending (1'b1),
      .valid      (vld),
      .left       (left_nb),
      .right      (right_nb),
      .front      (front_v),
      .self       (lo_nb[i])
    );
  end

  for (genvar i = 0; i < HI_CELLS; i++) begin : g_hi
    cell_nb_t left_nb;
    cell_nb_t right_nb;
    word_t    front_v;
    logic     vld;
    assign vld = (count_t'(i) < (cnt_eff - n_lo));
    if (i == 0) begin : g_head
      assign left_nb = NB_HEAD;
      assign front_v = lo_head;
    end else begin : g_body
      assign left_nb = hi_nb[i-1];
      assign front_v = hi_nb[i-1].val;
    end
    if (i == HI_CELLS - 1) begin : g_tail
      assign right_nb = NB_TAIL;
    end else begin : g_mid
      assign right_nb = hi_nb[i+1];
    end
    rmsi_cell u_cell (
      .clk        (clk),
      .cmd        (hi_cmd),
      .descending (1'b0),
      .valid      (vld),
      .left       (left_nb),
      .right      (right_nb),
      .front      (front_v),
      .self       (hi_nb[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
      out_drop  <= 1'b0;
    end else begin
      if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (full) begin
          cnt       <= cnt_eff;
          out_valid <= 1'b1;
          out_drop  <= 1'b1;
        end else begin
          cnt       <= cnt_eff + count_t'(1);
          out_valid <= !cnt_eff[0];
          out_drop  <= 1'b0;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_drop;
  assign m_tdata  = out_drop ? 32'd0 : 32'(hi_head);

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= count_t'(DEPTH))
    else $error("entry count above depth");

  a_drop_keeps: assert property (@(posedge clk) disable iff (rst)
    (accept && full) |=> (cnt == $past(cnt)))
    else $error("dropped item changed the count");

  a_first_one: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser) |=> (cnt == count_t'(1)))
    else $error("new data set did not start at one entry");

  a_median_odd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_drop) |-> cnt[0])
    else $error("median shown with an even count");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/rmsi_cell.sv @@
// one cell of a sorted chain: holds one entry, compares it with the new sample
// and takes its next value from itself, a neighbor, the sample or the front
// depends on rmsi_pkg
`default_nettype none

module rmsi_cell (
  input  logic              clk,
  input  rmsi_pkg::cell_cmd_t cmd,
  input  logic              descending,
  input  logic              valid,
  input  rmsi_pkg::cell_nb_t  left,
  input  rmsi_pkg::cell_nb_t  right,
  input  rmsi_pkg::word_t     front,
  output rmsi_pkg::cell_nb_t  self
);
  import rmsi_pkg::*;

  word_t val;
  word_t val_next;
  logic  keep;
  logic  pre;

  // keep: entry stays in place on insert; pre: entry strictly ahead of sample
  assign keep = valid && (descending ? (val >= cmd.value) : (val <= cmd.value));
  assign pre  = valid && (descending ? (val >  cmd.value) : (val <  cmd.value));

  always_comb begin
    unique case (cmd.op)
      OP_HOLD:   val_next = val;
      OP_INSERT: val_next = keep ? val : (!left.keep ? left.val : cmd.value);
      OP_POPINS: val_next = right.pre ? right.val : (pre ? cmd.value : val);
      OP_PUSH:   val_next = front;
      default:   val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  assign self = '{val: val, keep: keep, pre: pre};

endmodule

`default_nettype wire

@@ test/tb_running_median_sorted_insert.sv @@
// self-checking bench for running_median_sorted_insert: sorted-insert median predictor,
// queue-fed stream driver and result monitor, paced in several idle and stall phases
// depends on rmsi_pkg and running_median_sorted_insert
`default_nettype none

module tb_running_median_sorted_insert;
  import rmsi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    word_t value;
    logic  first;
  } sample_t;

  typedef struct packed {
    logic [31:0] median;
    logic        dropped;
  } median_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;  // value
  logic s_tuser = 1'b0;       // first
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;       // median
  logic m_tuser;              // dropped

  sample_t     sample_q[$];
  median_res_t median_q[$];
  word_t       held[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int mismatches = 0;
  int samples_sent = 0;
  int medians_seen = 0;
  int drops_seen = 0;

  running_median_sorted_insert u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // append one pending input item
  function automatic void queue_sample(input word_t v, input logic first);
    sample_t s;
    s.value = v;
    s.first = first;
    sample_q.insert(sample_q.size(), s);
  endfunction

  // insert into the sorted set and work out the median, if any, or a drop if full
  function automatic void insert_sample(input word_t v, input logic first);
    int pos;
    median_res_t res;
    if (first)
      held.delete();
    if (held.size() >= DEPTH) begin
      res.median = '0;
      res.dropped = 1'b1;
      median_q.insert(median_q.size(), res);
      return;
    end
    pos = held.size();
    while (pos > 0 && held[pos-1] > v)
      pos--;
    held.insert(pos, v);
    if (held.size() % 2 == 1) begin
      res.median = held[held.size() >> 1];
      res.dropped = 1'b0;
      median_q.insert(median_q.size(), res);
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want_med,
                               input logic want_drop);
    mismatches++;
    if (mismatches <= 10)
      $display("tb: mismatch (%s) cycle %0d: want %0d/%0b, got %0d/%0b",
               what, cycles, $signed(want_med), want_drop, $signed(m_tdata), m_tuser);
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3, 4: return word_t'($signed($urandom_range(16)) - 8);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic add_short_sets(input int n_items);
    int added;
    int len;
    added = 0;
    while (added < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(16, 60) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
        queue_sample(pick_value(), (i == 0) && ($urandom_range(9) != 0));
      added += len;
    end
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || s_tvalid || median_q.size() != 0)
      @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        insert_sample(word_t'(s_tdata), s_tuser);
        samples_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= sample_q[0].value;
          s_tuser <= sample_q[0].first;
          void'(sample_q.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_results
    median_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (m_tuser)
          drops_seen++;
        else
          medians_seen++;
        if (median_q.size() == 0) begin
          flag_mismatch("unexpected item", 'x, 1'bx);
        end else begin
          want = median_q.pop_front();
          if (m_tdata !== want.median)
            flag_mismatch("median", want.median, want.dropped);
          if (m_tuser !== want.dropped)
            flag_mismatch("dropped", want.median, want.dropped);
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    word_t dir_val[$];
    logic  dir_first[$];

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, duplicates, clears, even counts, empty set without first
    dir_val = '{32'sh0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh7fff_ffff, 32'shffff_ffff, 32'shffff_ffff,
                32'sh5, 32'sh4, 32'sh3, 32'sh2, 32'sh1,
                32'sh1, 32'sh2, 32'sh3, 32'sh4, 32'sh5,
                32'sh8000_0000, 32'sh7fff_ffff, 32'sh0,
                32'sh5555_5555, 32'shaaaa_aaaa};
    dir_first = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                  1'b1, 1'b0, 1'b0,
                  1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                  1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                  1'b1, 1'b0, 1'b0,
                  1'b1, 1'b1};
    foreach (dir_val[i])
      queue_sample(dir_val[i], dir_first[i]);
    add_short_sets(150);
    drain();

    // one set that fills the store, overflows, then restarts from full
    send_idle_pct = 51;
    stall_pct = 0;
    queue_sample(pick_value(), 1'b1);
    for (int i = 1; i < DEPTH + 6; i++)
      queue_sample(pick_value(), 1'b0);
    queue_sample(pick_value(), 1'b1);
    queue_sample(pick_value(), 1'b0);
    queue_sample(pick_value(), 1'b0);
    drain();

    send_idle_pct = 0;
    stall_pct = 51;
    add_short_sets(250);
    drain();

    send_idle_pct = 32;
    stall_pct = 32;
    add_short_sets(250);
    drain();

    repeat (20) @(posedge clk);
    mismatches += median_q.size();
    $display("tb: %0d samples in 4 pacing phases, %0d medians and %0d drops checked",
             samples_sent, medians_seen, drops_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
